// File: hdl/dwsd_pkg.sv
// Package for the double-word signed divider: transaction structs, status and
// sign-mode codes, register indexes. No dependencies.
package dwsd_pkg;

   localparam int FIELD_W = 64;
   localparam int N_W     = 7;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_DIV_ZERO = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   localparam logic [1:0] MODE_UNSIGNED = 2'd0;
   localparam logic [1:0] MODE_TWOS     = 2'd1;
   localparam logic [1:0] MODE_ONES     = 2'd2;
   localparam logic [1:0] MODE_SIGN_MAG = 2'd3;

   localparam logic REG_WORD_SIZE = 1'b0;
   localparam logic REG_SIGN_MODE = 1'b1;

   localparam logic ACTION_QUOTIENT  = 1'b0;
   localparam logic ACTION_REMAINDER = 1'b1;

   typedef struct packed {
      logic               action;
      logic [FIELD_W-1:0] dividend_high;
      logic [FIELD_W-1:0] dividend_low;
      logic [FIELD_W-1:0] divisor;
   } req_type;

   typedef struct packed {
      logic [FIELD_W-1:0] result_word;
      logic [1:0]         status;
      logic               flags_written;
      logic               carry;
   } rsp_type;

   // Per-transaction control carried alongside the divider chain
   typedef struct packed {
      logic action;
      logic dneg;
      logic xneg;
      logic dzero;
   } ctl_type;

endpackage

// File: hdl/dwsd_front.sv
// Operand preparation: masking to n bits, sign/magnitude extraction and
// alignment of the 2n-bit dividend. Two register stages. Uses dwsd_pkg.
module dwsd_front #(
   parameter int W = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     in_valid,
   input  dwsd_pkg::req_type        in_data,
   input  logic [dwsd_pkg::N_W-1:0] word_n,
   input  logic [1:0]               sign_mode,
   output logic                     out_valid,
   output logic [2*W-1:0]           out_work,
   output logic [W-1:0]             out_d,
   output dwsd_pkg::ctl_type        out_ctl
);
   import dwsd_pkg::*;

   logic [W-1:0] mask, lim, hi, lo, dv, hi_mag, lo_mag, x_mag;
   logic         signed_mode, hneg, xneg;

   logic             s1_valid_ff, s1_valid_in;
   logic [W-1:0]     s1_hi_ff, s1_lo_ff, s1_d_ff;
   ctl_type          s1_ctl_ff, s1_ctl_in;

   logic             s2_valid_ff, s2_valid_in;
   logic [2*W-1:0]   s2_work_ff, s2_work_in;
   logic [W-1:0]     s2_d_ff;
   ctl_type          s2_ctl_ff, s2_ctl_in;

   always_comb begin
      mask        = ~({W{1'b1}} << word_n);
      lim         = {{(W-1){1'b0}}, 1'b1} << (word_n - 7'd1);
      hi          = in_data.dividend_high[W-1:0] & mask;
      lo          = in_data.dividend_low[W-1:0] & mask;
      dv          = in_data.divisor[W-1:0] & mask;
      signed_mode = (sign_mode != MODE_UNSIGNED);
      hneg        = signed_mode && ((hi & lim) != '0);
      xneg        = signed_mode && ((dv & lim) != '0);

      x_mag = dv;
      if (xneg) begin
         case (sign_mode)
            MODE_TWOS: x_mag = (~dv + 1'b1) & mask;
            MODE_ONES: x_mag = ~dv & mask;
            default:   x_mag = dv & (mask >> 1);
         endcase
      end

      hi_mag = hi;
      lo_mag = lo;
      if (hneg) begin
         case (sign_mode)
            MODE_TWOS: begin
               lo_mag = (~lo + 1'b1) & mask;
               hi_mag = (~hi + W'(lo == '0)) & mask;
            end
            MODE_ONES: begin
               lo_mag = ~lo & mask;
               hi_mag = ~hi & mask;
            end
            default: hi_mag = hi & (mask >> 1);
         endcase
      end

      s1_valid_in      = in_valid;
      s1_ctl_in.action = in_data.action;
      s1_ctl_in.dneg   = hneg;
      s1_ctl_in.xneg   = xneg;
      s1_ctl_in.dzero  = 1'b0;

      // hi * 2^n + lo over 2n bits
      s2_valid_in     = s1_valid_ff;
      s2_work_in      = ({{W{1'b0}}, s1_hi_ff} << word_n) | {{W{1'b0}}, s1_lo_ff};
      s2_ctl_in       = s1_ctl_ff;
      s2_ctl_in.dzero = (s1_d_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      if (advance) begin
         s1_hi_ff   <= hi_mag;
         s1_lo_ff   <= lo_mag;
         s1_d_ff    <= x_mag;
         s1_ctl_ff  <= s1_ctl_in;
         s2_work_ff <= s2_work_in;
         s2_d_ff    <= s1_d_ff;
         s2_ctl_ff  <= s2_ctl_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_work  = s2_work_ff;
   assign out_d     = s2_d_ff;
   assign out_ctl   = s2_ctl_ff;

endmodule

// File: hdl/dwsd_cell.sv
// One restoring-division cell: brings in one dividend bit, trial-subtracts
// the divisor and shifts in one quotient bit. Uses dwsd_pkg.
module dwsd_cell #(
   parameter int W = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  logic [W-1:0]      in_r,
   input  logic [2*W-1:0]    in_work,
   input  logic [W-1:0]      in_d,
   input  dwsd_pkg::ctl_type in_ctl,
   output logic              out_valid,
   output logic [W-1:0]      out_r,
   output logic [2*W-1:0]    out_work,
   output logic [W-1:0]      out_d,
   output dwsd_pkg::ctl_type out_ctl
);
   import dwsd_pkg::*;

   logic [W:0]     rem_wide, rem_next;
   logic           ge;
   logic           valid_ff;
   logic [W-1:0]   r_ff, r_in, d_ff;
   logic [2*W-1:0] work_ff, work_in;
   ctl_type        ctl_ff;

   // work holds unused dividend bits at the top and quotient bits at the bottom
   always_comb begin
      rem_wide = {in_r, in_work[2*W-1]};
      ge       = (rem_wide >= {1'b0, in_d});
      rem_next = ge ? (rem_wide - {1'b0, in_d}) : rem_wide;
      r_in     = rem_next[W-1:0];
      work_in  = {in_work[2*W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         r_ff    <= r_in;
         work_ff <= work_in;
         d_ff    <= in_d;
         ctl_ff  <= in_ctl;
      end
   end

   assign out_valid = valid_ff;
   assign out_r     = r_ff;
   assign out_work  = work_ff;
   assign out_d     = d_ff;
   assign out_ctl   = ctl_ff;

endmodule

// File: hdl/dwsd_back.sv
// Result stage: overflow check, sign-mode encoding and the output register.
// Uses dwsd_pkg.
module dwsd_back #(
   parameter int W = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic [2*W-1:0]           in_q,
   input  logic [W-1:0]             in_r,
   input  dwsd_pkg::ctl_type        in_ctl,
   input  logic [dwsd_pkg::N_W-1:0] word_n,
   input  logic [1:0]               sign_mode,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output dwsd_pkg::rsp_type        rsp_data,
   output logic                     out_free
);
   import dwsd_pkg::*;

   function automatic logic [W-1:0] encode(input logic neg, input logic [W-1:0] mag,
                                           input logic [W-1:0] lim,
                                           input logic [W-1:0] mask,
                                           input logic [1:0] mode);
      logic [W-1:0] res;
      res = mag & mask;
      if (neg && (mag != '0)) begin
         case (mode)
            MODE_TWOS:     res = (~mag + 1'b1) & mask;
            MODE_ONES:     res = ~mag & mask;
            MODE_SIGN_MAG: res = (mag | lim) & mask;
            default:       res = mag & mask;
         endcase
      end
      return res;
   endfunction

   logic [W-1:0]   mask, lim;
   logic [2*W-1:0] lim_wide;
   logic           signed_mode, qneg, ovf, load;
   rsp_type        rsp_in;
   rsp_type        rsp_ff;
   logic           rsp_valid_ff, rsp_valid_in;

   always_comb begin
      mask        = ~({W{1'b1}} << word_n);
      lim         = {{(W-1){1'b0}}, 1'b1} << (word_n - 7'd1);
      lim_wide    = {{W{1'b0}}, lim};
      signed_mode = (sign_mode != MODE_UNSIGNED);
      qneg        = signed_mode && (in_ctl.dneg != in_ctl.xneg) && (in_q != '0);

      if (!signed_mode) begin
         ovf = ((in_q >> word_n) != '0);
      end else if (!qneg) begin
         ovf = (in_q >= lim_wide);
      end else begin
         // most negative value fits in two's complement only
         ovf = (in_q > lim_wide) || ((in_q == lim_wide) && (sign_mode != MODE_TWOS));
      end

      rsp_in.result_word   = '0;
      rsp_in.status        = STATUS_OK;
      rsp_in.flags_written = 1'b0;
      rsp_in.carry         = 1'b0;
      if (in_ctl.dzero) begin
         rsp_in.status = STATUS_DIV_ZERO;
      end else if (in_ctl.action == ACTION_REMAINDER) begin
         rsp_in.result_word = FIELD_W'(encode(in_ctl.dneg, in_r, lim, mask, sign_mode));
      end else if (ovf) begin
         rsp_in.status = STATUS_OVERFLOW;
      end else begin
         rsp_in.result_word   = FIELD_W'(encode(qneg, in_q[W-1:0], lim, mask, sign_mode));
         rsp_in.flags_written = 1'b1;
         rsp_in.carry         = (in_r != '0);
      end

      out_free     = !rsp_valid_ff || rsp_ready;
      load         = in_valid && out_free;
      rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: hdl/double_word_signed_divide.sv
// Top level of the double-word signed divider: register port, operand front
// end, chain of 2*MAX_WORD division cells, result stage. Uses dwsd_pkg.
//
//   channel  | direction | handshake           | payload
//   req      | in        | req_valid/req_ready | req_data (req_type)
//   rsp      | out       | rsp_valid/rsp_ready | rsp_data (rsp_type)
//   register | in/out    | psel/penable/pready | paddr, pwdata, prdata
//
// One transaction per cycle while req_ready is high. The path is two operand
// stages, one cell per dividend bit and one output register.
// Synchronous reset clears the valid bits and sets word_size 64, two's complement.
// The chain stalls only when its last cell holds a result and the output
// register is full and not being taken; req_ready drops in that case.
module double_word_signed_divide #(
   parameter int MAX_WORD = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dwsd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dwsd_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import dwsd_pkg::*;

   localparam int W     = MAX_WORD;
   localparam int CELLS = 2 * MAX_WORD;

   logic [N_W-1:0] word_size_ff, word_size_in;
   logic [1:0]     sign_mode_ff, sign_mode_in;
   logic [N_W-1:0] word_n;
   logic           wr_en, advance, out_free;

   logic           chain_valid [0:CELLS];
   logic [W-1:0]   chain_r     [0:CELLS];
   logic [2*W-1:0] chain_work  [0:CELLS];
   logic [W-1:0]   chain_d     [0:CELLS];
   ctl_type        chain_ctl   [0:CELLS];

   always_comb begin
      wr_en        = psel && penable && pwrite && pready;
      word_size_in = word_size_ff;
      sign_mode_in = sign_mode_ff;
      if (wr_en) begin
         case (paddr[2])
            REG_WORD_SIZE: word_size_in = pwdata[N_W-1:0];
            REG_SIGN_MODE: sign_mode_in = pwdata[1:0];
            default:       word_size_in = word_size_ff;
         endcase
      end
      case (paddr[2])
         REG_WORD_SIZE: prdata = {{(32-N_W){1'b0}}, word_size_ff};
         REG_SIGN_MODE: prdata = {30'd0, sign_mode_ff};
         default:       prdata = '0;
      endcase

      if (word_size_ff == '0) begin
         word_n = N_W'(1);
      end else if (word_size_ff > N_W'(W)) begin
         word_n = N_W'(W);
      end else begin
         word_n = word_size_ff;
      end

      advance   = out_free || !chain_valid[CELLS];
      req_ready = advance;
   end

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         word_size_ff <= N_W'(64);
         sign_mode_ff <= MODE_TWOS;
      end else begin
         word_size_ff <= word_size_in;
         sign_mode_ff <= sign_mode_in;
      end
   end

   dwsd_front #(.W(W)) u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .word_n    (word_n),
      .sign_mode (sign_mode_ff),
      .out_valid (chain_valid[0]),
      .out_work  (chain_work[0]),
      .out_d     (chain_d[0]),
      .out_ctl   (chain_ctl[0])
   );

   assign chain_r[0] = '0;

   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      dwsd_cell #(.W(W)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (chain_valid[i]),
         .in_r      (chain_r[i]),
         .in_work   (chain_work[i]),
         .in_d      (chain_d[i]),
         .in_ctl    (chain_ctl[i]),
         .out_valid (chain_valid[i+1]),
         .out_r     (chain_r[i+1]),
         .out_work  (chain_work[i+1]),
         .out_d     (chain_d[i+1]),
         .out_ctl   (chain_ctl[i+1])
      );
   end

   dwsd_back #(.W(W)) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_valid[CELLS]),
      .in_q      (chain_work[CELLS]),
      .in_r      (chain_r[CELLS]),
      .in_ctl    (chain_ctl[CELLS]),
      .word_n    (word_n),
      .sign_mode (sign_mode_ff),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .out_free  (out_free)
   );

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready && chain_valid[CELLS]) |-> !req_ready)
      else $error("input taken while chain is stalled");

   a_error_clears_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != STATUS_OK)) |->
      ((rsp_data.result_word == '0) && !rsp_data.flags_written && !rsp_data.carry))
      else $error("error result carries data or flags");

   a_carry_with_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.carry) |-> rsp_data.flags_written)
      else $error("carry without flags written");

   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

endmodule
